FILE: rtl/core/ssr_pkg.sv
`timescale 1ns / 1ps
package ssr_pkg;

    localparam int DIGIT_SLOTS = 8;
    localparam int SCALE_LIMIT = 10;

    localparam int DIGIT_W = 4;
    localparam int SCALE_W = 4;
    localparam int ROW_W   = 5;
    localparam int MASK_W  = 8;
    localparam int COUNT_W = 4;
    localparam int SEG_W   = 7;
    localparam int SEG_IDX_W = $clog2(SEG_W);
    localparam int IDX_W   = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;

    // segment bits
    localparam int SEG_TOP = 0;
    localparam int SEG_MID = 1;
    localparam int SEG_BOT = 2;
    localparam int SEG_UL  = 3;
    localparam int SEG_UR  = 4;
    localparam int SEG_LL  = 5;
    localparam int SEG_LR  = 6;

    typedef enum logic [4:0] {
        PH_TOP = 5'b00001,
        PH_UP  = 5'b00010,
        PH_MID = 5'b00100,
        PH_LOW = 5'b01000,
        PH_BOT = 5'b10000
    } t_phase;

    typedef struct packed {
        logic               load;
        logic               emit;
        logic               clear;
        t_phase             phase;
        logic [ROW_W-1:0]   row;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [ROW_W-1:0]   row_number;
        logic [MASK_W-1:0]  bar_mask;
        logic [MASK_W-1:0]  left_mask;
        logic [MASK_W-1:0]  right_mask;
        logic [COUNT_W-1:0] digits_shown;
        logic               final_row;
    } t_row_data;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'd125;
            4'd1:    s = 7'd80;
            4'd2:    s = 7'd55;
            4'd3:    s = 7'd87;
            4'd4:    s = 7'd90;
            4'd5:    s = 7'd79;
            4'd6:    s = 7'd111;
            4'd7:    s = 7'd81;
            4'd8:    s = 7'd127;
            4'd9:    s = 7'd95;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/core/ssr_ifs.sv
`timescale 1ns / 1ps
interface ssr_in_if import ssr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit_value;
    logic               last_digit;

    modport source (output valid, output digit_value, output last_digit, input ready);
    modport sink   (input valid, input digit_value, input last_digit, output ready);
endinterface

interface ssr_out_if import ssr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_number;
    logic [MASK_W-1:0]  bar_mask;
    logic [MASK_W-1:0]  left_mask;
    logic [MASK_W-1:0]  right_mask;
    logic [COUNT_W-1:0] digits_shown;
    logic               final_row;

    modport source (output valid, output row_number, output bar_mask, output left_mask,
                    output right_mask, output digits_shown, output final_row,
                    input ready);
    modport sink   (input valid, input row_number, input bar_mask, input left_mask,
                    input right_mask, input digits_shown, input final_row,
                    output ready);
endinterface

FILE: rtl/core/ssr_ctrl.sv
`timescale 1ns / 1ps
module ssr_ctrl import ssr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  t_stat              i_stat,
    output t_cmd               o_cmd
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [SCALE_W-1:0] r_scale;
    logic [SCALE_W-1:0] r_scale_eff, n_scale_eff;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [SCALE_W-1:0] scale_sat;
    logic [ROW_W-1:0]   s_ext;
    logic               accept;
    t_phase             phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_scale == '0) begin
            scale_sat = SCALE_W'(1);
        end else if (r_scale > SCALE_W'(SCALE_LIMIT)) begin
            scale_sat = SCALE_W'(SCALE_LIMIT);
        end else begin
            scale_sat = r_scale;
        end
    end

    assign o_in_ready = (r_state == ST_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign s_ext      = ROW_W'(r_scale_eff);

    // locate the current row within the rendering
    always_comb begin
        if (r_row == '0) begin
            phase = PH_TOP;
        end else if (r_row <= s_ext) begin
            phase = PH_UP;
        end else if (r_row == s_ext + ROW_W'(1)) begin
            phase = PH_MID;
        end else if (r_row <= {s_ext[ROW_W-2:0], 1'b0} + ROW_W'(1)) begin
            phase = PH_LOW;
        end else begin
            phase = PH_BOT;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_scale_eff = r_scale_eff;
        o_cmd       = '{load: 1'b0, emit: 1'b0, clear: 1'b0, phase: phase, row: r_row};
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = accept;
                if (accept && i_in_last) begin
                    n_state     = ST_EMIT;
                    n_row       = '0;
                    n_scale_eff = scale_sat;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (phase == PH_BOT) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_row       <= '0;
            r_scale_eff <= SCALE_W'(1);
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_scale_eff <= n_scale_eff;
        end
    end

endmodule

FILE: rtl/core/ssr_dpath.sv
`timescale 1ns / 1ps
module ssr_dpath import ssr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [DIGIT_W-1:0] i_digit,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_row_data          o_out_data
);

    logic [DIGIT_W-1:0]   r_store [DIGIT_SLOTS];
    logic [COUNT_W-1:0]   r_count;
    logic                 r_out_valid;
    t_row_data            r_out;
    logic [SEG_W-1:0]     lane_seg [DIGIT_SLOTS];
    logic [MASK_W-1:0]    mask_bar, mask_left, mask_right;
    logic [SEG_IDX_W-1:0] bar_bit, left_bit, right_bit;
    logic                 is_bar;

    // store digits in arrival order, drop once full
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < COUNT_W'(DIGIT_SLOTS))) begin
            r_store[r_count[IDX_W-1:0]] <= i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load && (r_count < COUNT_W'(DIGIT_SLOTS))) begin
            r_count <= r_count + COUNT_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            lane_seg[k] = (COUNT_W'(k) < r_count) ? seg_of(r_store[k]) : '0;
        end
    end

    always_comb begin
        bar_bit   = SEG_IDX_W'(SEG_TOP);
        left_bit  = SEG_IDX_W'(SEG_UL);
        right_bit = SEG_IDX_W'(SEG_UR);
        is_bar    = 1'b1;
        case (i_cmd.phase)
            PH_TOP: begin
                bar_bit = SEG_IDX_W'(SEG_TOP);
            end
            PH_UP: begin
                is_bar = 1'b0;
            end
            PH_MID: begin
                bar_bit = SEG_IDX_W'(SEG_MID);
            end
            PH_LOW: begin
                is_bar    = 1'b0;
                left_bit  = SEG_IDX_W'(SEG_LL);
                right_bit = SEG_IDX_W'(SEG_LR);
            end
            PH_BOT: begin
                bar_bit = SEG_IDX_W'(SEG_BOT);
            end
            default: begin
                is_bar = 1'b1;
            end
        endcase
    end

    always_comb begin
        mask_bar   = '0;
        mask_left  = '0;
        mask_right = '0;
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            if (k < MASK_W) begin
                mask_bar[k]   = is_bar  && lane_seg[k][bar_bit];
                mask_left[k]  = !is_bar && lane_seg[k][left_bit];
                mask_right[k] = !is_bar && lane_seg[k][right_bit];
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.row_number   <= i_cmd.row;
            r_out.bar_mask     <= mask_bar;
            r_out.left_mask    <= mask_left;
            r_out.right_mask   <= mask_right;
            r_out.digits_shown <= r_count;
            r_out.final_row    <= (i_cmd.phase == PH_BOT);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/scaled_seven_segment_rows.sv
`timescale 1ns / 1ps
// Seven-segment row generator.
// Digits enter on i_digit (valid/ready), most significant first, one beat per
// cycle while ready is high; up to eight are held and further digits are
// dropped. A beat with last_digit set ends the number: ready drops and the
// block sends 2*scale+3 rows on o_row, top bar first, one row per cycle while
// the receiver takes them. Once the last digit is accepted the controller
// enters its emit state, from which rows are loaded into the output register.
// Each row carries bar/left/right masks (bit k = k-th digit received), the
// digit count and final_row on the bottom bar. Ready returns once the bottom
// row is loaded into the output register; the row sequencer in the controller
// drives ready. A stalled receiver holds the current row in the output
// register and the sequencer waits. scale (i_cfg_we/i_cfg_data) saturates to
// 1..10 and is sampled when the last digit is accepted. Reset empties the
// digit store, sets scale to 1 and clears o_row.valid.
module scaled_seven_segment_rows import ssr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_data,
    ssr_in_if.sink             i_digit,
    ssr_out_if.source          o_row
);

    t_cmd      cmd;
    t_stat     stat;
    t_row_data out_data;
    logic      out_valid;

    ssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_digit.valid),
        .i_in_last  (i_digit.last_digit),
        .o_in_ready (i_digit.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_digit     (i_digit.digit_value),
        .i_out_ready (o_row.ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data)
    );

    assign o_row.valid        = out_valid;
    assign o_row.row_number   = out_data.row_number;
    assign o_row.bar_mask     = out_data.bar_mask;
    assign o_row.left_mask    = out_data.left_mask;
    assign o_row.right_mask   = out_data.right_mask;
    assign o_row.digits_shown = out_data.digits_shown;
    assign o_row.final_row    = out_data.final_row;

endmodule

FILE: rtl/core/ssr_checker.sv
`timescale 1ns / 1ps
module ssr_checker import ssr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_last,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ROW_W-1:0]   i_out_row,
    input logic [MASK_W-1:0]  i_out_bar,
    input logic [MASK_W-1:0]  i_out_left,
    input logic [MASK_W-1:0]  i_out_right,
    input logic [COUNT_W-1:0] i_out_count,
    input logic               i_out_final
);

    // stalled row holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row)
        && $stable(i_out_final) && $stable(i_out_bar))
        else $error("row changed while stalled");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input taken right after last digit");

    a_no_input_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_final |-> !i_in_ready)
        else $error("input open during row run");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_count != '0 && i_out_count <= COUNT_W'(DIGIT_SLOTS))
        else $error("digit count out of range");

    a_bar_or_stroke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_bar == '0) || (i_out_left == '0 && i_out_right == '0))
        else $error("bar and stroke in one row");

endmodule

bind scaled_seven_segment_rows ssr_checker u_ssr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_digit.valid),
    .i_in_ready  (i_digit.ready),
    .i_in_last   (i_digit.last_digit),
    .i_out_valid (o_row.valid),
    .i_out_ready (o_row.ready),
    .i_out_row   (o_row.row_number),
    .i_out_bar   (o_row.bar_mask),
    .i_out_left  (o_row.left_mask),
    .i_out_right (o_row.right_mask),
    .i_out_count (o_row.digits_shown),
    .i_out_final (o_row.final_row)
);

FILE: tb/tb_scaled_seven_segment_rows.sv
`timescale 1ns / 1ps
module tb_scaled_seven_segment_rows;
    import ssr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    // longest number plus the tallest rendering, with margin
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_DIGITS = 29;

    // segment bits per digit code; codes above nine light nothing
    localparam logic [SEG_W-1:0] SEGMENTS [16] = '{
        7'd125, 7'd80, 7'd55, 7'd87, 7'd90, 7'd79, 7'd111, 7'd81, 7'd127, 7'd95,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    typedef struct packed {
        logic [DIGIT_W-1:0] value;
        logic               last;
    } t_digit_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [SCALE_W-1:0] i_cfg_data = '0;

    ssr_in_if  digit_if ();
    ssr_out_if row_if ();

    scaled_seven_segment_rows dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_digit    (digit_if),
        .o_row      (row_if)
    );

    // row predictor state
    logic [SCALE_W-1:0] scale_setting = 4'd1;
    logic [DIGIT_W-1:0] held_digits [DIGIT_SLOTS];
    int                 held_count = 0;

    t_digit_beat pending_digits [$];
    t_row_data   expected_rows [$];
    t_row_data   wanted_row;
    t_digit_beat next_beat;

    int digits_queued = 0;
    int digits_taken = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int idle_pct = 10;
    bit hold_input = 1'b0;
    bit digit_taken = 1'b0;
    bit row_taken = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [MASK_W-1:0] got,
                               input logic [MASK_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("row %0d %s got %0h want %0h",
                                      wanted_row.row_number, name, got, want));
    endtask

    function automatic logic [MASK_W-1:0] lit_mask(input int seg);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < held_count && k < MASK_W; k++)
            m[k] = SEGMENTS[held_digits[k]][SEG_IDX_W'(seg)];
        return m;
    endfunction

    function automatic void push_row(input int row, input logic [MASK_W-1:0] bar,
                                     input logic [MASK_W-1:0] left,
                                     input logic [MASK_W-1:0] right, input logic fin);
        t_row_data r;
        r.row_number   = ROW_W'(row);
        r.bar_mask     = bar;
        r.left_mask    = left;
        r.right_mask   = right;
        r.digits_shown = COUNT_W'(held_count);
        r.final_row    = fin;
        expected_rows.push_back(r);
    endfunction

    // store the digit; on the last one, render all rows and empty the store
    function automatic void take_digit(input logic [DIGIT_W-1:0] value, input logic last);
        int s;
        if (held_count < DIGIT_SLOTS) begin
            held_digits[IDX_W'(held_count)] = value;
            held_count++;
        end
        if (last) begin
            s = int'(scale_setting);
            if (s < 1) s = 1;
            if (s > SCALE_LIMIT) s = SCALE_LIMIT;
            push_row(0, lit_mask(SEG_TOP), '0, '0, 1'b0);
            for (int i = 0; i < s; i++)
                push_row(1 + i, '0, lit_mask(SEG_UL), lit_mask(SEG_UR), 1'b0);
            push_row(s + 1, lit_mask(SEG_MID), '0, '0, 1'b0);
            for (int i = 0; i < s; i++)
                push_row(s + 2 + i, '0, lit_mask(SEG_LL), lit_mask(SEG_LR), 1'b0);
            push_row(2 * s + 2, lit_mask(SEG_BOT), '0, '0, 1'b1);
            held_count = 0;
        end
    endfunction

    // monitor: sample both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            digit_taken = 1'b0;
            row_taken = 1'b0;
            stall_cycles = 0;
        end else begin
            digit_taken = digit_if.valid && digit_if.ready;
            row_taken = row_if.valid && row_if.ready;
            if (i_cfg_we)
                scale_setting = i_cfg_data;
            if (row_taken) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch($sformatf("row %0d with nothing pending",
                                              row_if.row_number));
                end else begin
                    wanted_row = expected_rows.pop_front();
                    check_field("row_number", MASK_W'(row_if.row_number),
                                MASK_W'(wanted_row.row_number));
                    check_field("bar_mask", row_if.bar_mask, wanted_row.bar_mask);
                    check_field("left_mask", row_if.left_mask, wanted_row.left_mask);
                    check_field("right_mask", row_if.right_mask, wanted_row.right_mask);
                    check_field("digits_shown", MASK_W'(row_if.digits_shown),
                                MASK_W'(wanted_row.digits_shown));
                    check_field("final_row", MASK_W'(row_if.final_row),
                                MASK_W'(wanted_row.final_row));
                end
            end
            if (digit_taken) begin
                take_digit(digit_if.digit_value, digit_if.last_digit);
                digits_taken++;
            end
            stall_cycles = (digit_taken || row_taken) ? 0 : stall_cycles + 1;
        end
    end

    // driver: hold a beat until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            digit_if.valid <= 1'b0;
            row_if.ready <= 1'b0;
        end else begin
            row_if.ready <= (int'($urandom_range(99)) >= idle_pct);
            if (!digit_if.valid || digit_taken) begin
                if (!hold_input && pending_digits.size() != 0 &&
                    int'($urandom_range(99)) >= idle_pct) begin
                    next_beat = pending_digits.pop_front();
                    digit_if.valid <= 1'b1;
                    digit_if.digit_value <= next_beat.value;
                    digit_if.last_digit <= next_beat.last;
                end else begin
                    digit_if.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void queue_digit(input logic [DIGIT_W-1:0] value, input logic last);
        t_digit_beat b;
        b.value = value;
        b.last  = last;
        pending_digits.push_back(b);
        digits_queued++;
    endfunction

    function automatic void queue_number(input int len, input bit terminated);
        logic [DIGIT_W-1:0] v;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 10)
                v = DIGIT_W'($urandom_range(10, 15));
            else
                v = DIGIT_W'($urandom_range(0, 9));
            queue_digit(v, terminated && (i == len - 1));
        end
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (digits_taken != digits_queued || expected_rows.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write while idle, then return just after a rising edge
    task automatic write_scale(input logic [SCALE_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [SCALE_W-1:0] phase_scales [PHASES];
        int queued;
        int pick;

        digit_if.valid = 1'b0;
        digit_if.digit_value = '0;
        digit_if.last_digit = 1'b0;
        row_if.ready = 1'b0;

        phase_scales = '{4'd10, 4'd1, 4'd0, 4'd15, 4'd3, 4'd7, 4'd2, 4'd10};
        phase_scales[5] = SCALE_W'($urandom_range(0, 15));
        phase_scales[6] = SCALE_W'($urandom_range(2, 9));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset scale, one digit
        queue_digit(4'd8, 1'b1);

        // scale zero; full store, the last digit is dropped
        write_scale(4'd0);
        for (int d = 0; d < 8; d++)
            queue_digit(DIGIT_W'(d), 1'b0);
        queue_digit(4'd9, 1'b1);

        // scale above limit; blank codes
        write_scale(4'd15);
        queue_digit(4'd8, 1'b0);
        queue_digit(4'd9, 1'b0);
        queue_digit(4'd10, 1'b0);
        queue_digit(4'd15, 1'b1);

        write_scale(4'd10);
        queue_digit(4'd12, 1'b0);
        queue_digit(4'd6, 1'b0);
        queue_digit(4'd7, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            write_scale(phase_scales[p]);
            // one phase runs with no idling on either side
            idle_pct = (p == 2) ? 0 : 10;
            queued = 0;
            while (queued < PHASE_DIGITS) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    pick = $urandom_range(1, 8);
                    queue_number(pick, 1'b1);
                end else if (pick < 90) begin
                    pick = $urandom_range(9, 12);
                    queue_number(pick, 1'b1);
                end else begin
                    // broken number: no last digit, the rest carries over
                    pick = $urandom_range(1, 4);
                    queue_number(pick, 1'b0);
                end
                queued += pick;
            end
            if (p == 4) begin
                repeat (30) @(posedge i_clk);
                hold_input = 1'b1;
                do @(negedge i_clk);
                while (expected_rows.size() != 0);
                @(posedge i_clk);
                hold_input = 1'b0;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
